// ===== rtl/assert_macros.svh =====
// assertion helpers for the block checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/quadcb_pkg.sv =====
package quadcb_pkg;

   localparam int MAX_QUADS = 65536;
   localparam int KEPT_W    = $clog2(MAX_QUADS + 1);
   localparam int COORD_W   = 20;
   localparam int ID_W      = 32;
   localparam int INDEX_W   = 16;
   localparam int COUNT_W   = 17;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic            visible;
      logic [ID_W-1:0] texture;
      logic [ID_W-1:0] material;
      logic [ID_W-1:0] mask;
      logic            end_of_list;
   } quad_type;

   typedef struct packed {
      logic     valid;
      quad_type item;
   } quad_xfer_type;

endpackage

// ===== rtl/quadcb_front.sv =====
module quadcb_front (
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [quadcb_pkg::COORD_W-1:0]  req_rect_x,
   input  logic signed [quadcb_pkg::COORD_W-1:0]  req_rect_y,
   input  logic signed [quadcb_pkg::COORD_W-1:0]  req_rect_w,
   input  logic signed [quadcb_pkg::COORD_W-1:0]  req_rect_h,
   input  logic signed [quadcb_pkg::COORD_W-1:0]  req_clip_x,
   input  logic signed [quadcb_pkg::COORD_W-1:0]  req_clip_y,
   input  logic signed [quadcb_pkg::COORD_W-1:0]  req_clip_w,
   input  logic signed [quadcb_pkg::COORD_W-1:0]  req_clip_h,
   input  logic        [quadcb_pkg::ID_W-1:0]     req_texture_id,
   input  logic        [quadcb_pkg::ID_W-1:0]     req_material_id,
   input  logic        [quadcb_pkg::ID_W-1:0]     req_mask_id,
   input  logic                                   req_end_of_list,
   input  logic                                   queue_full,
   output quadcb_pkg::quad_xfer_type              push
);
   import quadcb_pkg::*;

   logic signed [COORD_W:0] rect_r, rect_b, clip_r, clip_b;
   logic signed [COORD_W:0] left, top, right, bottom;

   assign rect_r = {req_rect_x[COORD_W-1], req_rect_x} + {req_rect_w[COORD_W-1], req_rect_w};
   assign rect_b = {req_rect_y[COORD_W-1], req_rect_y} + {req_rect_h[COORD_W-1], req_rect_h};
   assign clip_r = {req_clip_x[COORD_W-1], req_clip_x} + {req_clip_w[COORD_W-1], req_clip_w};
   assign clip_b = {req_clip_y[COORD_W-1], req_clip_y} + {req_clip_h[COORD_W-1], req_clip_h};

   assign left   = (req_rect_x > req_clip_x) ? {req_rect_x[COORD_W-1], req_rect_x}
                                             : {req_clip_x[COORD_W-1], req_clip_x};
   assign top    = (req_rect_y > req_clip_y) ? {req_rect_y[COORD_W-1], req_rect_y}
                                             : {req_clip_y[COORD_W-1], req_clip_y};
   assign right  = (rect_r < clip_r) ? rect_r : clip_r;
   assign bottom = (rect_b < clip_b) ? rect_b : clip_b;

   assign req_stall              = queue_full;
   assign push.valid             = req_valid && !queue_full;
   assign push.item.visible      = (right > left) && (bottom > top);
   assign push.item.texture      = req_texture_id;
   assign push.item.material     = req_material_id;
   assign push.item.mask         = req_mask_id;
   assign push.item.end_of_list  = req_end_of_list;

endmodule

// ===== rtl/quadcb_queue.sv =====
module quadcb_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  quadcb_pkg::quad_xfer_type push,
   output logic                      full,
   output quadcb_pkg::quad_xfer_type head,
   input  logic                      pop
);
   import quadcb_pkg::*;

   quad_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

// ===== rtl/quadcb_back.sv =====
module quadcb_back (
   input  logic                               clock,
   input  logic                               reset,
   input  quadcb_pkg::quad_xfer_type          head,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [quadcb_pkg::INDEX_W-1:0]     rsp_first_index,
   output logic [quadcb_pkg::COUNT_W-1:0]     rsp_quad_count,
   output logic [quadcb_pkg::ID_W-1:0]        rsp_entry_texture,
   output logic [quadcb_pkg::ID_W-1:0]        rsp_entry_material,
   output logic [quadcb_pkg::ID_W-1:0]        rsp_entry_mask,
   output logic                               rsp_last_entry,
   output logic                               rsp_overflow
);
   import quadcb_pkg::*;

   typedef struct packed {
      logic [INDEX_W-1:0] first_index;
      logic [COUNT_W-1:0] quad_count;
      logic [ID_W-1:0]    texture;
      logic [ID_W-1:0]    material;
      logic [ID_W-1:0]    mask;
      logic               last_entry;
      logic               overflow;
   } entry_type;

   logic [KEPT_W-1:0] kept_ff, kept_in;
   logic              open_ff, open_in;
   logic [KEPT_W-1:0] start_ff, start_in;
   logic [KEPT_W-1:0] len_ff, len_in;
   logic [ID_W-1:0]   tex_ff, tex_in, mat_ff, mat_in, msk_ff, msk_in;
   logic              ovf_ff, ovf_in;

   entry_type         rsp_ff, rsp_in, pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in, pend_valid_ff, pend_valid_in;

   quad_type          h;
   logic              out_free, take, kept_full, vis_cnt, ovf_new, match, close;
   entry_type         closing, final_entry;

   assign h         = head.item;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign take      = head.valid && out_free && !pend_valid_ff;
   assign pop       = take;
   assign kept_full = (kept_ff == KEPT_W'(MAX_QUADS));
   assign vis_cnt   = h.visible && !kept_full;
   assign ovf_new   = ovf_ff || (h.visible && kept_full);
   assign match     = open_ff && (tex_ff == h.texture) && (mat_ff == h.material)
                      && (msk_ff == h.mask);
   assign close     = vis_cnt && open_ff && !match;

   always_comb begin
      open_in  = open_ff;
      start_in = start_ff;
      len_in   = len_ff;
      tex_in   = tex_ff;
      mat_in   = mat_ff;
      msk_in   = msk_ff;
      kept_in  = kept_ff;
      if (vis_cnt) begin
         if (match) begin
            len_in = len_ff + 1'b1;
         end else begin
            open_in  = 1'b1;
            start_in = kept_ff;
            len_in   = KEPT_W'(1);
            tex_in   = h.texture;
            mat_in   = h.material;
            msk_in   = h.mask;
         end
         kept_in = kept_ff + 1'b1;
      end

      closing.first_index = INDEX_W'(start_ff);
      closing.quad_count  = COUNT_W'(len_ff);
      closing.texture     = tex_ff;
      closing.material    = mat_ff;
      closing.mask        = msk_ff;
      closing.last_entry  = 1'b0;
      closing.overflow    = ovf_new;

      if (open_in) begin
         final_entry.first_index = INDEX_W'(start_in);
         final_entry.quad_count  = COUNT_W'(len_in);
         final_entry.texture     = tex_in;
         final_entry.material    = mat_in;
         final_entry.mask        = msk_in;
      end else begin
         final_entry.first_index = '0;
         final_entry.quad_count  = '0;
         final_entry.texture     = '0;
         final_entry.material    = '0;
         final_entry.mask        = '0;
      end
      final_entry.last_entry = 1'b1;
      final_entry.overflow   = ovf_new;
   end

   always_ff @(posedge clock) begin
      if (reset || (take && h.end_of_list)) begin
         kept_ff  <= '0;
         open_ff  <= 1'b0;
         start_ff <= '0;
         len_ff   <= '0;
         tex_ff   <= '0;
         mat_ff   <= '0;
         msk_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (take) begin
         kept_ff  <= kept_in;
         open_ff  <= open_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         tex_ff   <= tex_in;
         mat_ff   <= mat_in;
         msk_ff   <= msk_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign ovf_in = ovf_new;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (pend_valid_ff && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = pend_ff;
         pend_valid_in = 1'b0;
      end else if (take && (close || h.end_of_list)) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = close ? closing : final_entry;
         pend_valid_in = close && h.end_of_list;
         pend_in       = final_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_first_index    = rsp_ff.first_index;
   assign rsp_quad_count     = rsp_ff.quad_count;
   assign rsp_entry_texture  = rsp_ff.texture;
   assign rsp_entry_material = rsp_ff.material;
   assign rsp_entry_mask     = rsp_ff.mask;
   assign rsp_last_entry     = rsp_ff.last_entry;
   assign rsp_overflow       = rsp_ff.overflow;

endmodule

// ===== rtl/quad_cull_and_batch_top.sv =====
// quad cull and batch
// req channel: one quad per item (rect, clip, three binding ids, end_of_list),
// accepted when req_valid is high and req_stall is low.
// rsp channel: one draw entry per item (first index, count, ids, last_entry,
// overflow), taken when rsp_valid is high and rsp_stall is low.
// a quad is culled in the front stage and written into a 4-deep queue; the
// back stage pops one queued quad per cycle while rsp is free and nothing is
// pending, updates the open run and loads the output register, so an entry
// shows on rsp after its quad has passed through the queue and that register.
// throughput is one quad per cycle without rsp stalls; a quad closing a run
// at list end yields two entries, holding the back stage till the second loads.
// when rsp_stall is high the output register and one pending entry hold,
// the queue fills and req_stall rises once its 4 slots are taken.
// synchronous reset empties the queue, drops any pending entry and clears the
// run state, so the next quad starts a new list.
module quad_cull_and_batch_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [quadcb_pkg::COORD_W-1:0]  req_rect_x,
   input  logic signed [quadcb_pkg::COORD_W-1:0]  req_rect_y,
   input  logic signed [quadcb_pkg::COORD_W-1:0]  req_rect_w,
   input  logic signed [quadcb_pkg::COORD_W-1:0]  req_rect_h,
   input  logic signed [quadcb_pkg::COORD_W-1:0]  req_clip_x,
   input  logic signed [quadcb_pkg::COORD_W-1:0]  req_clip_y,
   input  logic signed [quadcb_pkg::COORD_W-1:0]  req_clip_w,
   input  logic signed [quadcb_pkg::COORD_W-1:0]  req_clip_h,
   input  logic        [quadcb_pkg::ID_W-1:0]     req_texture_id,
   input  logic        [quadcb_pkg::ID_W-1:0]     req_material_id,
   input  logic        [quadcb_pkg::ID_W-1:0]     req_mask_id,
   input  logic                                   req_end_of_list,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic        [quadcb_pkg::INDEX_W-1:0]  rsp_first_index,
   output logic        [quadcb_pkg::COUNT_W-1:0]  rsp_quad_count,
   output logic        [quadcb_pkg::ID_W-1:0]     rsp_entry_texture,
   output logic        [quadcb_pkg::ID_W-1:0]     rsp_entry_material,
   output logic        [quadcb_pkg::ID_W-1:0]     rsp_entry_mask,
   output logic                                   rsp_last_entry,
   output logic                                   rsp_overflow
);
   import quadcb_pkg::*;

   quad_xfer_type push, head;
   logic          queue_full, pop;

   quadcb_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rect_x      (req_rect_x),
      .req_rect_y      (req_rect_y),
      .req_rect_w      (req_rect_w),
      .req_rect_h      (req_rect_h),
      .req_clip_x      (req_clip_x),
      .req_clip_y      (req_clip_y),
      .req_clip_w      (req_clip_w),
      .req_clip_h      (req_clip_h),
      .req_texture_id  (req_texture_id),
      .req_material_id (req_material_id),
      .req_mask_id     (req_mask_id),
      .req_end_of_list (req_end_of_list),
      .queue_full      (queue_full),
      .push            (push)
   );

   quadcb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   quadcb_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_first_index    (rsp_first_index),
      .rsp_quad_count     (rsp_quad_count),
      .rsp_entry_texture  (rsp_entry_texture),
      .rsp_entry_material (rsp_entry_material),
      .rsp_entry_mask     (rsp_entry_mask),
      .rsp_last_entry     (rsp_last_entry),
      .rsp_overflow       (rsp_overflow)
   );

endmodule

// ===== rtl/quadcb_checker.sv =====
`include "assert_macros.svh"

module quadcb_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [quadcb_pkg::INDEX_W-1:0]     rsp_first_index,
   input logic [quadcb_pkg::COUNT_W-1:0]     rsp_quad_count,
   input logic [quadcb_pkg::ID_W-1:0]        rsp_entry_texture,
   input logic [quadcb_pkg::ID_W-1:0]        rsp_entry_material,
   input logic [quadcb_pkg::ID_W-1:0]        rsp_entry_mask,
   input logic                               rsp_last_entry
);
   import quadcb_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_first_index) && $stable(rsp_quad_count) && $stable(rsp_entry_texture) && $stable(rsp_last_entry))
   `ASSERT_IMPLIES(a_empty_entry, clock, reset, rsp_valid && (rsp_quad_count == '0), rsp_last_entry && (rsp_first_index == '0) && (rsp_entry_texture == '0) && (rsp_entry_material == '0) && (rsp_entry_mask == '0))
   `ASSERT_IMPLIES(a_mid_entry_nonzero, clock, reset, rsp_valid && !rsp_last_entry, rsp_quad_count != '0)
   `ASSERT_IMPLIES(a_idle_after_reset, clock, reset, $past(reset), !rsp_valid)

endmodule

bind quad_cull_and_batch_top quadcb_checker u_quadcb_checker (.*);

// ===== test/quad_batch_checker.sv =====
`timescale 1ns / 1ps

module quad_batch_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [quadcb_pkg::COORD_W-1:0] req_rect_x,
   input  logic signed [quadcb_pkg::COORD_W-1:0] req_rect_y,
   input  logic signed [quadcb_pkg::COORD_W-1:0] req_rect_w,
   input  logic signed [quadcb_pkg::COORD_W-1:0] req_rect_h,
   input  logic signed [quadcb_pkg::COORD_W-1:0] req_clip_x,
   input  logic signed [quadcb_pkg::COORD_W-1:0] req_clip_y,
   input  logic signed [quadcb_pkg::COORD_W-1:0] req_clip_w,
   input  logic signed [quadcb_pkg::COORD_W-1:0] req_clip_h,
   input  logic        [quadcb_pkg::ID_W-1:0]    req_texture_id,
   input  logic        [quadcb_pkg::ID_W-1:0]    req_material_id,
   input  logic        [quadcb_pkg::ID_W-1:0]    req_mask_id,
   input  logic                                  req_end_of_list,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic        [quadcb_pkg::INDEX_W-1:0] rsp_first_index,
   input  logic        [quadcb_pkg::COUNT_W-1:0] rsp_quad_count,
   input  logic        [quadcb_pkg::ID_W-1:0]    rsp_entry_texture,
   input  logic        [quadcb_pkg::ID_W-1:0]    rsp_entry_material,
   input  logic        [quadcb_pkg::ID_W-1:0]    rsp_entry_mask,
   input  logic                                  rsp_last_entry,
   input  logic                                  rsp_overflow,
   output int                                    errors,
   output int                                    pending
);
   import quadcb_pkg::*;

   typedef struct packed {
      logic [INDEX_W-1:0] first_index;
      logic [COUNT_W-1:0] quad_count;
      logic [ID_W-1:0]    texture;
      logic [ID_W-1:0]    material;
      logic [ID_W-1:0]    mask;
      logic               last_entry;
      logic               overflow;
   } draw_entry_type;

   draw_entry_type entries_due[$];

   logic [KEPT_W-1:0] kept_total;
   logic              run_open;
   logic [KEPT_W-1:0] run_start;
   logic [KEPT_W-1:0] run_length;
   logic [ID_W-1:0]   run_texture;
   logic [ID_W-1:0]   run_material;
   logic [ID_W-1:0]   run_mask;
   logic              overflow_seen;

   initial begin
      errors  = 0;
      pending = 0;
   end

   function automatic void clear_list();
      kept_total    = '0;
      run_open      = 1'b0;
      run_start     = '0;
      run_length    = '0;
      run_texture   = '0;
      run_material  = '0;
      run_mask      = '0;
      overflow_seen = 1'b0;
   endfunction

   function automatic void add_entry(input logic [KEPT_W-1:0] first,
                                     input logic [KEPT_W-1:0] count,
                                     input logic [ID_W-1:0] tex,
                                     input logic [ID_W-1:0] mat,
                                     input logic [ID_W-1:0] msk,
                                     input logic last);
      draw_entry_type e;
      e.first_index = first[INDEX_W-1:0];
      e.quad_count  = count[COUNT_W-1:0];
      e.texture     = tex;
      e.material    = mat;
      e.mask        = msk;
      e.last_entry  = last;
      e.overflow    = overflow_seen;
      entries_due   = {entries_due, e};
   endfunction

   // cull against the clip, then extend or close the open run and, at end_of_list, queue the final entry
   function automatic void batch_quad();
      logic signed [COORD_W:0] left, top, right, bottom, rr, cr, rb, cb;
      logic                    visible;
      left   = (req_rect_x > req_clip_x) ? req_rect_x : req_clip_x;
      top    = (req_rect_y > req_clip_y) ? req_rect_y : req_clip_y;
      rr     = req_rect_x + req_rect_w;
      cr     = req_clip_x + req_clip_w;
      rb     = req_rect_y + req_rect_h;
      cb     = req_clip_y + req_clip_h;
      right  = (rr < cr) ? rr : cr;
      bottom = (rb < cb) ? rb : cb;
      visible = (right > left) && (bottom > top);
      if (visible) begin
         if (kept_total >= MAX_QUADS) begin
            overflow_seen = 1'b1;
         end else begin
            if (run_open && run_texture == req_texture_id &&
                run_material == req_material_id && run_mask == req_mask_id) begin
               run_length++;
            end else begin
               if (run_open) begin
                  add_entry(run_start, run_length, run_texture, run_material,
                            run_mask, 1'b0);
               end
               run_open     = 1'b1;
               run_start    = kept_total;
               run_length   = KEPT_W'(1);
               run_texture  = req_texture_id;
               run_material = req_material_id;
               run_mask     = req_mask_id;
            end
            kept_total++;
         end
      end
      if (req_end_of_list) begin
         if (run_open) begin
            add_entry(run_start, run_length, run_texture, run_material, run_mask, 1'b1);
         end else begin
            add_entry('0, '0, '0, '0, '0, 1'b1);
         end
         clear_list();
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   function automatic void check_entry();
      draw_entry_type want;
      if (entries_due.size() == 0) begin
         $display("%0t: unexpected entry, expected none, actual first_index %0h count %0h",
                  $time, rsp_first_index, rsp_quad_count);
         errors++;
      end else begin
         want = entries_due.pop_front();
         check_field("first_index", want.first_index, rsp_first_index);
         check_field("quad_count", want.quad_count, rsp_quad_count);
         check_field("entry_texture", want.texture, rsp_entry_texture);
         check_field("entry_material", want.material, rsp_entry_material);
         check_field("entry_mask", want.mask, rsp_entry_mask);
         check_field("last_entry", want.last_entry, rsp_last_entry);
         check_field("overflow", want.overflow, rsp_overflow);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_list();
         entries_due.delete();
      end else begin
         if (req_valid && !req_stall) begin
            batch_quad();
         end
         if (rsp_valid && !rsp_stall) begin
            check_entry();
         end
      end
      pending = entries_due.size();
   end

endmodule

// ===== test/quad_cull_and_batch_top_tb.sv =====
`timescale 1ns / 1ps

module quad_cull_and_batch_top_tb;
   import quadcb_pkg::*;

   typedef enum logic [1:0] {QUAD_VISIBLE, QUAD_CULLED, QUAD_NOISE} quad_kind_type;

   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [ID_W-1:0]           ID_ONES   = '1;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_rect_x;
   logic signed [COORD_W-1:0] req_rect_y;
   logic signed [COORD_W-1:0] req_rect_w;
   logic signed [COORD_W-1:0] req_rect_h;
   logic signed [COORD_W-1:0] req_clip_x;
   logic signed [COORD_W-1:0] req_clip_y;
   logic signed [COORD_W-1:0] req_clip_w;
   logic signed [COORD_W-1:0] req_clip_h;
   logic        [ID_W-1:0]    req_texture_id;
   logic        [ID_W-1:0]    req_material_id;
   logic        [ID_W-1:0]    req_mask_id;
   logic                      req_end_of_list;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic        [INDEX_W-1:0] rsp_first_index;
   logic        [COUNT_W-1:0] rsp_quad_count;
   logic        [ID_W-1:0]    rsp_entry_texture;
   logic        [ID_W-1:0]    rsp_entry_material;
   logic        [ID_W-1:0]    rsp_entry_mask;
   logic                      rsp_last_entry;
   logic                      rsp_overflow;

   logic no_idle = 1'b0;
   int   errors;
   int   pending;
   int   quads_sent;

   quad_cull_and_batch_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rect_x         (req_rect_x),
      .req_rect_y         (req_rect_y),
      .req_rect_w         (req_rect_w),
      .req_rect_h         (req_rect_h),
      .req_clip_x         (req_clip_x),
      .req_clip_y         (req_clip_y),
      .req_clip_w         (req_clip_w),
      .req_clip_h         (req_clip_h),
      .req_texture_id     (req_texture_id),
      .req_material_id    (req_material_id),
      .req_mask_id        (req_mask_id),
      .req_end_of_list    (req_end_of_list),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_first_index    (rsp_first_index),
      .rsp_quad_count     (rsp_quad_count),
      .rsp_entry_texture  (rsp_entry_texture),
      .rsp_entry_material (rsp_entry_material),
      .rsp_entry_mask     (rsp_entry_mask),
      .rsp_last_entry     (rsp_last_entry),
      .rsp_overflow       (rsp_overflow)
   );

   quad_batch_checker entry_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rect_x         (req_rect_x),
      .req_rect_y         (req_rect_y),
      .req_rect_w         (req_rect_w),
      .req_rect_h         (req_rect_h),
      .req_clip_x         (req_clip_x),
      .req_clip_y         (req_clip_y),
      .req_clip_w         (req_clip_w),
      .req_clip_h         (req_clip_h),
      .req_texture_id     (req_texture_id),
      .req_material_id    (req_material_id),
      .req_mask_id        (req_mask_id),
      .req_end_of_list    (req_end_of_list),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_first_index    (rsp_first_index),
      .rsp_quad_count     (rsp_quad_count),
      .rsp_entry_texture  (rsp_entry_texture),
      .rsp_entry_material (rsp_entry_material),
      .rsp_entry_mask     (rsp_entry_mask),
      .rsp_last_entry     (rsp_last_entry),
      .rsp_overflow       (rsp_overflow),
      .errors             (errors),
      .pending            (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 20);
   end

   initial begin
      #20_000_000;
      $display("quad_cull_and_batch_top: mismatch");
      $finish;
   end

   task automatic send_quad(input logic signed [COORD_W-1:0] rx, ry, rw, rh,
                            input logic signed [COORD_W-1:0] cx, cy, cw, ch,
                            input logic [ID_W-1:0] tex, mat, msk,
                            input logic eol);
      logic stalled;
      while (!no_idle && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_rect_x      <= rx;
      req_rect_y      <= ry;
      req_rect_w      <= rw;
      req_rect_h      <= rh;
      req_clip_x      <= cx;
      req_clip_y      <= cy;
      req_clip_w      <= cw;
      req_clip_h      <= ch;
      req_texture_id  <= tex;
      req_material_id <= mat;
      req_mask_id     <= msk;
      req_end_of_list <= eol;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      quads_sent++;
   endtask

   task automatic send_kind(input quad_kind_type kind, input logic [ID_W-1:0] tex, mat, msk,
                            input logic eol);
      logic signed [COORD_W-1:0] rx, ry, rw, rh, cx, cy, cw, ch;
      rx = COORD_W'($urandom);
      ry = COORD_W'($urandom);
      rw = COORD_W'($urandom_range(1, COORD_MAX));
      rh = COORD_W'($urandom_range(1, COORD_MAX));
      cx = rx;
      cy = ry;
      cw = COORD_W'($urandom_range(1, COORD_MAX));
      ch = COORD_W'($urandom_range(1, COORD_MAX));
      case (kind)
         QUAD_CULLED: begin
            case ($urandom_range(3))
               0: rw = '0;
               1: rh = {1'b1, (COORD_W-1)'($urandom)};
               2: cx = rx + rw;
               default: cy = ry + rh;
            endcase
         end
         QUAD_NOISE: begin
            rw = COORD_W'($urandom);
            rh = COORD_W'($urandom);
            cx = COORD_W'($urandom);
            cy = COORD_W'($urandom);
            cw = COORD_W'($urandom);
            ch = COORD_W'($urandom);
         end
         default: ;
      endcase
      send_quad(rx, ry, rw, rh, cx, cy, cw, ch, tex, mat, msk, eol);
   endtask

   // one list with runs of shared bindings, each id changing on its own
   task automatic send_list(input int length, input int visible_pct);
      logic [ID_W-1:0] tex, mat, msk;
      quad_kind_type   kind;
      int              r;
      tex = $urandom;
      mat = $urandom;
      msk = $urandom;
      for (int i = 0; i < length; i++) begin
         r = $urandom_range(99);
         if (r < 15) begin
            tex = $urandom;
         end else if (r < 25) begin
            mat = $urandom;
         end else if (r < 35) begin
            msk = $urandom;
         end
         r = $urandom_range(99);
         if (r < visible_pct) begin
            kind = QUAD_VISIBLE;
         end else if (r < 90) begin
            kind = QUAD_CULLED;
         end else begin
            kind = QUAD_NOISE;
         end
         send_kind(kind, tex, mat, msk, i == length - 1);
      end
   endtask

   initial begin
      int n;
      quads_sent      = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_rect_x      <= '0;
      req_rect_y      <= '0;
      req_rect_w      <= '0;
      req_rect_h      <= '0;
      req_clip_x      <= '0;
      req_clip_y      <= '0;
      req_clip_w      <= '0;
      req_clip_h      <= '0;
      req_texture_id  <= '0;
      req_material_id <= '0;
      req_mask_id     <= '0;
      req_end_of_list <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty list
      send_quad(0, 0, 0, 16, 0, 0, 16, 16, 32'h1, 32'h2, 32'h3, 1'b1);
      // merge, culled quad inside a run, then each id changing alone
      send_quad(0, 0, 16, 16, 0, 0, 16, 16, 32'ha, 32'hb, 32'hc, 1'b0);
      send_quad(0, 0, 16, 16, 0, 0, 16, 16, 32'ha, 32'hb, 32'hc, 1'b0);
      send_quad(0, 0, 16, 16, 16, 0, 16, 16, ID_ONES, ID_ONES, ID_ONES, 1'b0);
      send_quad(0, 0, 16, 16, 0, 0, 16, 16, 32'ha, 32'hb, 32'hc, 1'b0);
      send_quad(0, 0, 16, 16, 0, 0, 16, 16, 32'hd, 32'hb, 32'hc, 1'b0);
      send_quad(0, 0, 16, 16, 0, 0, 16, 16, 32'hd, 32'he, 32'hc, 1'b0);
      send_quad(0, 0, 16, 16, 0, 0, 16, 16, 32'hd, 32'he, 32'hf, 1'b0);
      send_quad(0, 0, 16, -16, 0, 0, 16, 16, 32'hd, 32'he, 32'hf, 1'b1);
      // coordinate extremes, edge sums past 20 bits, end on a binding change
      send_quad(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, '0, '0, '0, 1'b0);
      send_quad(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, '0, '0, '0, 1'b0);
      send_quad(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, '0, '0, '0, 1'b0);
      send_quad(-1, -1, 2, 2, 0, 0, 1, 1, ID_ONES, ID_ONES, ID_ONES, 1'b1);
      // single visible quad ending its list
      send_quad(COORD_MAX, COORD_MIN, 1, 1, COORD_MAX, COORD_MIN, 1, 1,
                32'h5, 32'h6, 32'h7, 1'b1);
      // merge into the quad that ends the list
      send_quad(0, 0, 1, 1, 0, 0, 1, 1, 32'h8, 32'h9, 32'h8, 1'b0);
      send_quad(0, 0, 1, 1, 0, 0, 1, 1, 32'h8, 32'h9, 32'h8, 1'b1);
      // visible run, then a culled quad with a min-size clip ending the list
      send_quad(0, 0, 1, 1, 0, 0, 1, 1, 32'h8, 32'h9, 32'h8, 1'b0);
      send_quad(0, 0, 16, 16, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                32'h8, 32'h9, 32'h8, 1'b1);

      n = 0;
      while (n < 500) begin
         int length;
         no_idle = (n >= 200 && n < 320);
         length = $urandom_range(1, 12);
         send_list(length, ($urandom_range(9) == 0) ? 0 : 70);
         n += length;
      end
      no_idle = 1'b0;

      req_valid <= 1'b0;
      @(posedge clock);
      do @(negedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("quad_cull_and_batch_top: match");
      end else begin
         $display("quad_cull_and_batch_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/quadcb_pkg.sv
rtl/quadcb_front.sv
rtl/quadcb_queue.sv
rtl/quadcb_back.sv
rtl/quad_cull_and_batch_top.sv
rtl/quadcb_checker.sv
test/quad_batch_checker.sv
test/quad_cull_and_batch_top_tb.sv
